// ===== hw/rtl/numeric_char_ref_decoder_core_defines.svh =====
// Assertion macros used by the decoder checker.
`ifndef NUMERIC_CHAR_REF_DECODER_CORE_DEFINES_SVH
`define NUMERIC_CHAR_REF_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nrd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nrd assertion failed");

`endif

// ===== hw/rtl/nrd_pkg.sv =====
// Types, constants and lookup functions of the character reference decoder.
`timescale 1ns / 1ps
package nrd_pkg;

  localparam logic [20:0] MaxCp       = 21'h10FFFF;
  localparam logic [20:0] C0Last      = 21'h00001F;
  localparam logic [20:0] DelChar     = 21'h00007F;
  localparam logic [20:0] OvrFirst    = 21'h000080;
  localparam logic [20:0] OvrLast     = 21'h00009F;
  localparam logic [20:0] NonCharLo   = 21'h00FDD0;
  localparam logic [20:0] NonCharHi   = 21'h00FDEF;
  localparam logic [15:0] NonCharFffe = 16'hFFFE;
  localparam logic [15:0] NonCharFfff = 16'hFFFF;
  localparam logic [4:0]  MaxPlane    = 5'h10;
  localparam logic [20:0] CharTab     = 21'h000009;
  localparam logic [20:0] CharLf      = 21'h00000A;
  localparam logic [20:0] CharFf      = 21'h00000C;
  localparam logic [15:0] ConsumedMax = 16'hFFFF;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [7:0] AsciiLowA  = 8'h61;
  localparam logic [7:0] AsciiLowF  = 8'h66;
  localparam logic [7:0] AsciiUpA   = 8'h41;
  localparam logic [7:0] AsciiUpF   = 8'h46;
  localparam logic [7:0] AsciiLowX  = 8'h78;
  localparam logic [7:0] AsciiUpX   = 8'h58;

  typedef enum logic [2:0] {
    PhIdle   = 3'b001,
    PhPrefix = 3'b010,
    PhDigits = 3'b100
  } nrd_phase_e;

  typedef struct packed {
    logic        is_digit;
    logic [3:0]  value;
  } nrd_digit_t;

  typedef struct packed {
    logic        ok;
    logic [20:0] code_point;
  } nrd_verdict_t;

  // Digit value of a character in base 10 or 16.
  function automatic nrd_digit_t nrd_digit(input logic [7:0] c, input logic hex);
    nrd_digit_t r;
    r = '0;
    if (c inside {[AsciiZero:AsciiNine]}) begin
      r.is_digit = 1'b1;
      r.value    = 4'(c - AsciiZero);
    end else if (hex && (c inside {[AsciiLowA:AsciiLowF]})) begin
      r.is_digit = 1'b1;
      r.value    = 4'(c - AsciiLowA + 8'd10);
    end else if (hex && (c inside {[AsciiUpA:AsciiUpF]})) begin
      r.is_digit = 1'b1;
      r.value    = 4'(c - AsciiUpA + 8'd10);
    end
    return r;
  endfunction

  // Replacement code points for 0x80..0x9F; zero marks a slot with no mapping.
  function automatic logic [15:0] nrd_override(input logic [4:0] idx);
    logic [15:0] m;
    case (idx)
      5'h00:   m = 16'h20AC;
      5'h02:   m = 16'h201A;
      5'h03:   m = 16'h0192;
      5'h04:   m = 16'h201E;
      5'h05:   m = 16'h2026;
      5'h06:   m = 16'h2020;
      5'h07:   m = 16'h2021;
      5'h08:   m = 16'h02C6;
      5'h09:   m = 16'h2030;
      5'h0A:   m = 16'h0160;
      5'h0B:   m = 16'h2039;
      5'h0C:   m = 16'h0152;
      5'h0E:   m = 16'h017D;
      5'h11:   m = 16'h2018;
      5'h12:   m = 16'h2019;
      5'h13:   m = 16'h201C;
      5'h14:   m = 16'h201D;
      5'h15:   m = 16'h2022;
      5'h16:   m = 16'h2013;
      5'h17:   m = 16'h2014;
      5'h18:   m = 16'h02DC;
      5'h19:   m = 16'h2122;
      5'h1A:   m = 16'h0161;
      5'h1B:   m = 16'h203A;
      5'h1C:   m = 16'h0153;
      5'h1E:   m = 16'h017E;
      5'h1F:   m = 16'h0178;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/nrd_req_if.sv =====
// Request channel: one character of the reference body.
`timescale 1ns / 1ps
interface nrd_req_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] char_in;

  modport source (output valid, start_req, char_in, input ready);
  modport sink   (input valid, start_req, char_in, output ready);
endinterface

// ===== hw/rtl/nrd_rsp_if.sv =====
// Response channel: verdict, code point and consumed count.
`timescale 1ns / 1ps
interface nrd_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [20:0] code_point;
  logic [15:0] consumed;

  modport source (output valid, ok, code_point, consumed, input ready);
  modport sink   (input valid, ok, code_point, consumed, output ready);
endinterface

// ===== hw/rtl/nrd_judge.sv =====
// Code point verdict: range checks and the 0x80..0x9F override table.
`timescale 1ns / 1ps
module nrd_judge
  import nrd_pkg::*;
(
  input  logic [20:0]  value_i,
  input  logic         too_large_i,
  output nrd_verdict_t verdict_o
);

  logic [15:0] ovr;

  assign ovr = nrd_override(value_i[4:0]);

  always_comb begin
    verdict_o.ok         = 1'b1;
    verdict_o.code_point = value_i;
    if (too_large_i) begin
      verdict_o.ok = 1'b0;
    end else if (value_i <= C0Last) begin
      // TAB, LF and FF are the only allowed controls
      verdict_o.ok = (value_i == CharTab) || (value_i == CharLf) ||
                     (value_i == CharFf);
    end else if (value_i == DelChar) begin
      verdict_o.ok = 1'b0;
    end else if (value_i inside {[OvrFirst:OvrLast]}) begin
      verdict_o.ok         = (ovr != 16'h0000);
      verdict_o.code_point = 21'(ovr);
    end else if (value_i inside {[NonCharLo:NonCharHi]}) begin
      verdict_o.ok = 1'b0;
    end else if (((value_i[15:0] == NonCharFffe) || (value_i[15:0] == NonCharFfff)) &&
                 (value_i[20:16] <= MaxPlane)) begin
      verdict_o.ok = 1'b0;
    end
    if (!verdict_o.ok) begin
      verdict_o.code_point = '0;
    end
  end

endmodule

// ===== hw/rtl/numeric_char_ref_decoder_core.sv =====
// Top level of the numeric character reference decoder.
// A request that ends the reference passes the input register, then the result
// register. Throughput: one request per cycle while the result slot is free or
// being drained; the decode and the x10/x16 accumulate sit in the single stage
// between the two registers.
// Reset: rst_ni clears the valid flags, the phase, hex mode, value and count.
`timescale 1ns / 1ps
module numeric_char_ref_decoder_core
  import nrd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  nrd_req_if.sink      req_i,
  nrd_rsp_if.source    rsp_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic       in_start_q;
  logic [7:0] in_char_q;

  // decoder state
  nrd_phase_e            phase_q, phase_d;
  logic                  hex_q, hex_d;
  logic [20:0]           acc_q, acc_d;
  logic                  tl_q, tl_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  // result register
  logic        out_vld_q, out_vld_d;
  logic        out_ok_q;
  logic [20:0] out_cp_q;
  logic [15:0] out_cnt_q;

  logic                  proc;
  logic                  in_fire;
  logic                  emit;
  logic                  res_ok;
  logic [20:0]           res_cp;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [31:0]           res_cnt_ext;
  logic [COUNT_BITS-1:0] cnt_inc;
  nrd_digit_t            dig;
  logic                  dig_hex;
  logic [24:0]           acc_ext;
  logic [24:0]           acc_next;
  nrd_verdict_t          verdict;

  nrd_judge u_judge (
    .value_i     (acc_q),
    .too_large_i (tl_q),
    .verdict_o   (verdict)
  );

  // advance a held request whenever the result slot is free or being drained
  assign proc    = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign in_fire = req_i.valid && req_i.ready;
  assign req_i.ready = !in_vld_q || proc;

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  // prefix phase takes hex digits; start only looks for decimal ones
  assign dig_hex = !in_start_q && ((phase_q == PhPrefix) || hex_q);
  assign dig     = nrd_digit(in_char_q, dig_hex);
  assign acc_ext = {4'b0000, acc_q};
  assign acc_next = (hex_q ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1))) +
                    25'(dig.value);

  always_comb begin
    phase_d = phase_q;
    hex_d   = hex_q;
    acc_d   = acc_q;
    tl_d    = tl_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    res_ok  = 1'b0;
    res_cp  = '0;
    res_cnt = cnt_q;
    if (in_start_q) begin
      acc_d = '0;
      tl_d  = 1'b0;
      if ((in_char_q == AsciiLowX) || (in_char_q == AsciiUpX)) begin
        hex_d   = 1'b1;
        cnt_d   = COUNT_BITS'(1);
        phase_d = PhPrefix;
      end else begin
        hex_d = 1'b0;
        if (dig.is_digit) begin
          acc_d   = 21'(dig.value);
          cnt_d   = COUNT_BITS'(1);
          phase_d = PhDigits;
        end else begin
          cnt_d   = '0;
          phase_d = PhIdle;
          emit    = 1'b1;
          res_cnt = '0;
        end
      end
    end else begin
      case (phase_q)
        PhPrefix: begin
          if (dig.is_digit) begin
            acc_d   = 21'(dig.value);
            cnt_d   = cnt_inc;
            phase_d = PhDigits;
          end else begin
            phase_d = PhIdle;
            emit    = 1'b1;
          end
        end
        PhDigits: begin
          if (dig.is_digit) begin
            // freeze the value once it has gone past the last code point
            if (!tl_q) begin
              if (acc_next > 25'(MaxCp)) begin
                tl_d = 1'b1;
              end else begin
                acc_d = acc_next[20:0];
              end
            end
            cnt_d = cnt_inc;
          end else begin
            phase_d = PhIdle;
            emit    = 1'b1;
            res_ok  = verdict.ok;
            res_cp  = verdict.code_point;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_cnt_ext = 32'(res_cnt);

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (proc && emit) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PhIdle;
      hex_q     <= 1'b0;
      acc_q     <= '0;
      tl_q      <= 1'b0;
      cnt_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (proc) begin
        phase_q <= phase_d;
        hex_q   <= hex_d;
        acc_q   <= acc_d;
        tl_q    <= tl_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_start_q <= req_i.start_req;
      in_char_q  <= req_i.char_in;
    end
    if (proc && emit) begin
      out_ok_q  <= res_ok;
      out_cp_q  <= res_cp;
      out_cnt_q <= (res_cnt_ext > 32'(ConsumedMax)) ? ConsumedMax : res_cnt_ext[15:0];
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.ok         = out_ok_q;
  assign rsp_o.code_point = out_cp_q;
  assign rsp_o.consumed   = out_cnt_q;

endmodule

// ===== hw/rtl/nrd_checker.sv =====
// Port-level checks on the decoder response channel, bound to the top level.
`timescale 1ns / 1ps
`include "numeric_char_ref_decoder_core_defines.svh"
module nrd_checker
  import nrd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_ok_i,
  input logic [20:0] rsp_code_point_i,
  input logic [15:0] rsp_consumed_i
);

  // hold a stalled response
  `NRD_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `NRD_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(rsp_ok_i) && $stable(rsp_code_point_i) && $stable(rsp_consumed_i))
  // a rejection carries no code point
  `NRD_ASSERT_NOW(a_reject_zero, clk_i, rst_ni, rsp_valid_i && !rsp_ok_i, rsp_code_point_i == 21'h0)
  // an accepted reference has consumed at least one character and is within MaxCp
  `NRD_ASSERT_NOW(a_accept_sane, clk_i, rst_ni, rsp_valid_i && rsp_ok_i, (rsp_consumed_i != 16'h0) && (rsp_code_point_i <= MaxCp))

endmodule

bind numeric_char_ref_decoder_core nrd_checker u_nrd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_ok_i         (rsp_o.ok),
  .rsp_code_point_i (rsp_o.code_point),
  .rsp_consumed_i   (rsp_o.consumed)
);
